@@ rtl/crc_bit_serial_encode_check_assert.svh @@
// Assertion macros shared by the CRC bit-serial encoder/checker RTL.
`ifndef CRC_BIT_SERIAL_ENCODE_CHECK_ASSERT_SVH
`define CRC_BIT_SERIAL_ENCODE_CHECK_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CBS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CBS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/crcbs_pkg.sv @@
// Package of types and constants for the bit-serial CRC encoder/checker.
package crcbs_pkg;

	localparam int unsigned POLY_W    = 32;
	localparam int unsigned DEG_W     = 6;
	localparam int unsigned CFG_IDX_W = 1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLY   = 1'b0,
		REG_DEGREE = 1'b1
	} cfg_reg_t;

	localparam logic [POLY_W-1:0] POLY_RESET = 32'h04C1_1DB7;
	localparam logic [DEG_W-1:0]  DEG_RESET  = 6'd32;

	// Input action codes
	localparam logic ACTION_ENCODE = 1'b0;
	localparam logic ACTION_CHECK  = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_RUN,
		ST_ZERO,
		ST_UNLOAD
	} state_t;

	// Control shared by every cell of the remainder chain
	typedef struct packed {
		logic shift;
		logic fb_en;
		logic clear;
	} cell_ctl_t;

endpackage

@@ rtl/crcbs_if.sv @@
// Handshake interfaces: bit input, result output and configuration write.
interface crcbs_in_if;
	logic valid;
	logic ready;
	logic action;
	logic data_bit;
	logic is_final;

	modport source (output valid, output action, output data_bit, output is_final,
		input ready);
	modport sink (input valid, input action, input data_bit, input is_final,
		output ready);
endinterface

interface crcbs_out_if;
	logic valid;
	logic ready;
	logic out_bit;
	logic out_last;
	logic is_verdict;
	logic check_ok;

	modport source (output valid, output out_bit, output out_last, output is_verdict,
		output check_ok, input ready);
	modport sink (input valid, input out_bit, input out_last, input is_verdict,
		input check_ok, output ready);
endinterface

interface crcbs_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [crcbs_pkg::CFG_IDX_W-1:0]      index;
	logic [crcbs_pkg::POLY_W-1:0]         data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/crcbs_cell.sv @@
// One remainder bit of the CRC division chain.
module crcbs_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crcbs_pkg::cell_ctl_t ctl,
	input  logic                 in_bit,
	input  logic                 fb,
	input  logic                 poly_bit,
	input  logic                 en,
	output logic                 q,
	output logic                 sh
);

	// value this bit takes on a shift; bits at or above the degree drop to zero
	assign sh = en & (in_bit ^ (fb & poly_bit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= 1'b0;
		end else if (ctl.clear) begin
			q <= 1'b0;
		end else if (ctl.shift) begin
			q <= sh;
		end
	end

endmodule

@@ rtl/crcbs_chain.sv @@
// Row of remainder cells; each shifts into its upper neighbor with shared feedback.
module crcbs_chain #(
	parameter int unsigned MAX_DEGREE = 32,
	parameter int unsigned DW         = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  crcbs_pkg::cell_ctl_t  ctl,
	input  logic                  data_in,
	input  logic [MAX_DEGREE-1:0] poly,
	input  logic [DW-1:0]         deg_m1,
	output logic [MAX_DEGREE-1:0] rem,
	output logic [MAX_DEGREE-1:0] sh_vec,
	output logic                  top
);

	logic fb;

	// bit d-1 leaves the register and folds the polynomial back in
	assign top = rem[deg_m1];
	assign fb  = top & ctl.fb_en;

	for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_cell
		logic in_bit;
		logic en;

		if (i == 0) begin : g_head
			assign in_bit = data_in;
		end else begin : g_link
			assign in_bit = rem[i-1];
		end

		assign en = (DW'(i) <= deg_m1);

		crcbs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.in_bit   (in_bit),
			.fb       (fb),
			.poly_bit (poly[i]),
			.en       (en),
			.q        (rem[i]),
			.sh       (sh_vec[i])
		);
	end

endmodule

@@ rtl/crc_bit_serial_encode_check.sv @@
// A passthrough bit or a check verdict is offered in the cycle after its bit is taken.
// Throughput: one bit per cycle while the output is free, except a final encode bit, which
//   blocks the input while d zero bits flush through the cell chain, then d check beats.
// Check bits go out one per cycle from the top cell when not stalled, highest term first.
// Reset: polynomial 0x04C11DB7, degree 32, remainder cleared, output empty.
`include "crc_bit_serial_encode_check_assert.svh"

module crc_bit_serial_encode_check #(
	parameter int unsigned MAX_DEGREE = 32
) (
	input logic         clk,
	input logic         arst_n,
	crcbs_in_if.sink    msg,
	crcbs_out_if.source res,
	crcbs_cfg_if.sink   cfg
);

	localparam int unsigned DW      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam logic [6:0]  DEG_CAP = 7'(MAX_DEGREE);

	logic [crcbs_pkg::POLY_W-1:0] poly_q;
	logic [crcbs_pkg::DEG_W-1:0]  deg_q;
	logic [MAX_DEGREE-1:0]        poly_ext;
	logic [6:0]                   deg_raw;
	logic [6:0]                   deg_eff;
	logic [DW-1:0]                deg_m1;

	crcbs_pkg::state_t    state_q, state_d;
	logic [DW-1:0]        cnt_q, cnt_d;
	crcbs_pkg::cell_ctl_t ctl;
	logic                 chain_din;
	logic [MAX_DEGREE-1:0] rem;
	logic [MAX_DEGREE-1:0] sh_vec;
	logic                 top;

	logic out_free;
	logic load_out;
	logic o_bit, o_last, o_verd, o_ok;
	logic out_valid_q;
	logic out_bit_q, out_last_q, is_verdict_q, check_ok_q;
	logic msg_acc;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= crcbs_pkg::POLY_RESET;
			deg_q  <= crcbs_pkg::DEG_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == crcbs_pkg::REG_POLY) begin
				poly_q <= cfg.data;
			end else if (cfg.index == crcbs_pkg::REG_DEGREE) begin
				deg_q <= cfg.data[crcbs_pkg::DEG_W-1:0];
			end
		end
	end

	// polynomial sized to the chain; terms above the register width are zero
	for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_poly
		if (i < crcbs_pkg::POLY_W) begin : g_bit
			assign poly_ext[i] = poly_q[i];
		end else begin : g_zero
			assign poly_ext[i] = 1'b0;
		end
	end

	// effective degree: zero taken as one, clamped to the chain length
	assign deg_raw = {1'b0, deg_q};
	assign deg_eff = (deg_raw == 7'd0) ? 7'd1 : ((deg_raw > DEG_CAP) ? DEG_CAP : deg_raw);
	assign deg_m1  = DW'(deg_eff - 7'd1);

	crcbs_chain #(
		.MAX_DEGREE (MAX_DEGREE),
		.DW         (DW)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.data_in (chain_din),
		.poly    (poly_ext),
		.deg_m1  (deg_m1),
		.rem     (rem),
		.sh_vec  (sh_vec),
		.top     (top)
	);

	assign out_free = !out_valid_q || res.ready;
	assign msg_acc  = msg.valid && msg.ready;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crcbs_pkg::ST_RUN;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// next state, chain control and output load
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		ctl       = '0;
		chain_din = 1'b0;
		load_out  = 1'b0;
		o_bit     = 1'b0;
		o_last    = 1'b0;
		o_verd    = 1'b0;
		o_ok      = 1'b0;
		msg.ready = 1'b0;
		unique case (state_q)
			crcbs_pkg::ST_RUN: begin
				msg.ready = out_free;
				if (msg.valid && out_free) begin
					ctl.shift = 1'b1;
					ctl.fb_en = 1'b1;
					chain_din = msg.data_bit;
					if (msg.action == crcbs_pkg::ACTION_ENCODE) begin
						load_out = 1'b1;
						o_bit    = msg.data_bit;
						if (msg.is_final) begin
							state_d = crcbs_pkg::ST_ZERO;
							cnt_d   = deg_m1;
						end
					end else if (msg.is_final) begin
						// verdict on the remainder after this bit, then start afresh
						load_out  = 1'b1;
						o_last    = 1'b1;
						o_verd    = 1'b1;
						o_ok      = ~|sh_vec;
						ctl.clear = 1'b1;
					end
				end
			end
			crcbs_pkg::ST_ZERO: begin
				// append d zero bits to the dividend
				ctl.shift = 1'b1;
				ctl.fb_en = 1'b1;
				cnt_d     = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = crcbs_pkg::ST_UNLOAD;
					cnt_d   = deg_m1;
				end
			end
			crcbs_pkg::ST_UNLOAD: begin
				// plain shift out of the top cell; the chain ends up all zero
				if (out_free) begin
					load_out  = 1'b1;
					o_bit     = top;
					o_last    = (cnt_q == '0);
					ctl.shift = 1'b1;
					cnt_d     = cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_d = crcbs_pkg::ST_RUN;
					end
				end
			end
			default: begin
				state_d = crcbs_pkg::ST_RUN;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && !res.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_bit_q    <= o_bit;
			out_last_q   <= o_last;
			is_verdict_q <= o_verd;
			check_ok_q   <= o_ok;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.out_bit    = out_bit_q;
	assign res.out_last   = out_last_q;
	assign res.is_verdict = is_verdict_q;
	assign res.check_ok   = check_ok_q;

	// checks
	`CBS_ASSERT_NXT(a_enc_final_flush,
		msg_acc && (msg.action == crcbs_pkg::ACTION_ENCODE) && msg.is_final,
		state_q == crcbs_pkg::ST_ZERO, "encode final bit did not start the zero flush")
	`CBS_ASSERT_NXT(a_chk_final_clear,
		msg_acc && (msg.action == crcbs_pkg::ACTION_CHECK) && msg.is_final,
		(rem == '0) && res.valid && res.is_verdict, "check final bit left remainder or no verdict")
	`CBS_ASSERT_NXT(a_unload_done,
		(state_q == crcbs_pkg::ST_UNLOAD) && load_out && (cnt_q == '0),
		(state_q == crcbs_pkg::ST_RUN) && (rem == '0) && res.out_last,
		"unload ended without a cleared remainder and a last beat")
	`CBS_ASSERT_IMP(a_no_verdict_in_flush,
		state_q != crcbs_pkg::ST_RUN, !o_verd, "verdict raised during flush or unload")

endmodule

@@ test/tb.sv @@
// Testbench for the bit-serial CRC encoder/checker: directed and random bit streams.
`timescale 1ns / 100ps

module tb;

	localparam int unsigned MAX_DEG      = 32;
	localparam int          SETTLE       = 4;
	localparam int          DRAIN        = 8;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          LIMIT_CYCLES = 400000;
	localparam int          RANDOM_BITS  = 100;
	localparam int          PHASE_RUNS   = 4;

	// One output beat as the block presents it
	typedef struct packed {
		logic out_bit;
		logic out_last;
		logic is_verdict;
		logic check_ok;
	} crc_beat_t;

	logic clk;
	logic arst_n;

	crcbs_in_if  msg_if ();
	crcbs_out_if res_if ();
	crcbs_cfg_if cfg_if ();

	crc_bit_serial_encode_check #(
		.MAX_DEGREE(MAX_DEG)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// Mirror of the block's configuration and running remainder
	logic [crcbs_pkg::POLY_W-1:0] cfg_poly;
	logic [crcbs_pkg::DEG_W-1:0]  cfg_deg;
	logic [31:0]                  crc_rem;
	crc_beat_t                    crc_out_due[$];

	int err_count;
	int bits_sent;
	int cycle_count;
	bit steady;
	int hold_asks;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic note_error(input string what);
		err_count++;
		if (err_count <= 10)
			$display("%0t: %s", $time, what);
	endtask

	// Degree as the block uses it: 0 acts as 1, anything above the maximum is clipped
	function automatic int unsigned used_degree(input logic [crcbs_pkg::DEG_W-1:0] dg);
		if (dg == 0)
			return 1;
		if (dg > MAX_DEG)
			return MAX_DEG;
		return dg;
	endfunction

	// One bit of GF(2) long division by x^d + poly
	function automatic logic [31:0] div_step(input logic [31:0] r, input logic b,
			input int unsigned d, input logic [31:0] poly);
		logic [63:0] mask;
		logic [63:0] nxt;
		logic        top;
		mask = (64'd1 << d) - 64'd1;
		top  = r[d-1];
		nxt  = (({32'd0, r} << 1) | {63'd0, b}) & mask;
		if (top)
			nxt ^= {32'd0, poly} & mask;
		return nxt[31:0];
	endfunction

	// Work out the beats caused by one accepted bit
	function automatic void predict_crc_output(input logic act, input logic b, input logic fin);
		int unsigned d;
		crc_beat_t   beat;
		d = used_degree(cfg_deg);
		crc_rem = div_step(crc_rem, b, d, cfg_poly);
		if (act == crcbs_pkg::ACTION_ENCODE) begin
			beat = '{out_bit: b, out_last: 1'b0, is_verdict: 1'b0, check_ok: 1'b0};
			crc_out_due.push_back(beat);
			if (fin) begin
				for (int i = 0; i < d; i++)
					crc_rem = div_step(crc_rem, 1'b0, d, cfg_poly);
				for (int i = d; i > 0; i--) begin
					beat = '{out_bit: crc_rem[i-1], out_last: (i == 1),
						is_verdict: 1'b0, check_ok: 1'b0};
					crc_out_due.push_back(beat);
				end
				crc_rem = '0;
			end
		end else if (fin) begin
			beat = '{out_bit: 1'b0, out_last: 1'b1, is_verdict: 1'b1,
				check_ok: (crc_rem == 0)};
			crc_out_due.push_back(beat);
			crc_rem = '0;
		end
	endfunction

	// Offer one bit; valid stays high on return so back-to-back beats need no drop
	task automatic send_bit(input logic act, input logic b, input logic fin);
		if (!steady && $urandom_range(99) < 15) begin
			msg_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		msg_if.valid    <= 1'b1;
		msg_if.action   <= act;
		msg_if.data_bit <= b;
		msg_if.is_final <= fin;
		do @(posedge clk); while (!msg_if.ready);
		predict_crc_output(act, b, fin);
		bits_sent++;
		@(negedge clk);
	endtask

	// Stop offering and wait until the block has nothing left to deliver
	task automatic quiesce(input int extra);
		msg_if.valid <= 1'b0;
		while (crc_out_due.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// Write polynomial then degree; valid held across both beats
	task automatic write_cfg(input logic [crcbs_pkg::POLY_W-1:0] poly,
			input logic [crcbs_pkg::DEG_W-1:0] deg);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= crcbs_pkg::REG_POLY;
		cfg_if.data  <= poly;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_poly = poly;
		@(negedge clk);
		cfg_if.index <= crcbs_pkg::REG_DEGREE;
		cfg_if.data  <= {{(crcbs_pkg::POLY_W - crcbs_pkg::DEG_W){1'b0}}, deg};
		do @(posedge clk); while (!cfg_if.ready);
		cfg_deg = deg;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic send_message(input int n);
		for (int i = 0; i < n; i++)
			send_bit(crcbs_pkg::ACTION_ENCODE, 1'($urandom_range(1)), i == n - 1);
	endtask

	// Random message plus its check bits, fed to the checker; optionally one bit flipped
	task automatic send_codeword(input int n_msg, input bit corrupt);
		bit          cw[$];
		bit          b;
		int          idx;
		int unsigned d;
		logic [31:0] r;
		d = used_degree(cfg_deg);
		r = '0;
		for (int i = 0; i < n_msg; i++) begin
			b = 1'($urandom_range(1));
			cw.push_back(b);
			r = div_step(r, b, d, cfg_poly);
		end
		for (int i = 0; i < d; i++)
			r = div_step(r, 1'b0, d, cfg_poly);
		for (int i = d; i > 0; i--)
			cw.push_back(r[i-1]);
		if (corrupt) begin
			idx = $urandom_range(cw.size() - 1);
			cw[idx] = ~cw[idx];
		end
		for (int i = 0; i < cw.size(); i++)
			send_bit(crcbs_pkg::ACTION_CHECK, cw[i], i == cw.size() - 1);
	endtask

	// Random actions and bits, closed by a final bit
	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++)
			send_bit(1'($urandom_range(1)), 1'($urandom_range(1)), i == n - 1);
	endtask

	// Reset polynomial and degree, no writes yet
	task automatic test_reset_config();
		send_bit(crcbs_pkg::ACTION_ENCODE, 1'b1, 1'b0);
		send_bit(crcbs_pkg::ACTION_ENCODE, 1'b0, 1'b1);
		send_bit(crcbs_pkg::ACTION_CHECK, 1'b1, 1'b0);
		send_bit(crcbs_pkg::ACTION_CHECK, 1'b0, 1'b1);
	endtask

	// Smallest degree, degree 0, degrees past the maximum, poly bits above degree
	task automatic test_degree_extremes();
		quiesce(SETTLE);
		write_cfg(32'h0000_0001, 6'd1);
		send_bit(crcbs_pkg::ACTION_ENCODE, 1'b1, 1'b0);
		send_bit(crcbs_pkg::ACTION_ENCODE, 1'b1, 1'b0);
		send_bit(crcbs_pkg::ACTION_ENCODE, 1'b1, 1'b1);
		send_codeword(2, 1'b0);
		quiesce(SETTLE);
		write_cfg(32'hFFFF_FFFF, 6'd0);
		send_bit(crcbs_pkg::ACTION_ENCODE, 1'b1, 1'b1);
		quiesce(SETTLE);
		write_cfg(32'h0000_0000, 6'd63);
		send_bit(crcbs_pkg::ACTION_ENCODE, 1'b1, 1'b1);
		quiesce(SETTLE);
		write_cfg($urandom(), 6'd33);
		send_bit(crcbs_pkg::ACTION_ENCODE, 1'b0, 1'b1);
	endtask

	// Encode and check bits interleaved in one run share the remainder
	task automatic test_mode_mix();
		quiesce(SETTLE);
		write_cfg(32'h0000_0007, 6'd8);
		send_bit(crcbs_pkg::ACTION_ENCODE, 1'b1, 1'b0);
		send_bit(crcbs_pkg::ACTION_CHECK, 1'b1, 1'b0);
		send_bit(crcbs_pkg::ACTION_ENCODE, 1'b0, 1'b1);
		send_bit(crcbs_pkg::ACTION_CHECK, 1'b1, 1'b0);
		send_bit(crcbs_pkg::ACTION_ENCODE, 1'b0, 1'b0);
		send_bit(crcbs_pkg::ACTION_CHECK, 1'b0, 1'b1);
	endtask

	// Degree changed while a run is half done
	task automatic test_config_midrun();
		quiesce(SETTLE);
		write_cfg(32'h0000_1021, 6'd16);
		send_bit(crcbs_pkg::ACTION_CHECK, 1'b1, 1'b0);
		send_bit(crcbs_pkg::ACTION_CHECK, 1'b1, 1'b0);
		send_bit(crcbs_pkg::ACTION_CHECK, 1'b0, 1'b0);
		quiesce(SETTLE);
		write_cfg(32'h0000_0005, 6'd5);
		send_bit(crcbs_pkg::ACTION_CHECK, 1'b1, 1'b1);
		quiesce(SETTLE);
		write_cfg(32'h0000_0FFF, 6'd12);
		send_bit(crcbs_pkg::ACTION_ENCODE, 1'b1, 1'b0);
		quiesce(SETTLE);
		write_cfg($urandom(), 6'd3);
		send_bit(crcbs_pkg::ACTION_ENCODE, 1'b1, 1'b1);
	endtask

	// Receiver holds off while full-degree messages keep coming
	task automatic test_output_stall();
		quiesce(SETTLE);
		write_cfg($urandom(), 6'd32);
		hold_asks++;
		for (int i = 0; i < 3; i++)
			send_message(4);
	endtask

	// Phases of random configuration, each with a mix of runs
	task automatic test_random_traffic();
		int          goal;
		int          phase;
		int          pick;
		logic [5:0]  deg;
		goal  = bits_sent + RANDOM_BITS;
		phase = 0;
		while (bits_sent < goal) begin
			quiesce(SETTLE);
			pick = $urandom_range(99);
			if (pick < 60)
				deg = 6'($urandom_range(1, 8));
			else if (pick < 80)
				deg = 6'($urandom_range(9, 32));
			else if (pick < 90)
				deg = 6'd32;
			else
				deg = $urandom_range(1) ? 6'd0 : 6'($urandom_range(33, 63));
			write_cfg($urandom(), deg);
			steady = (phase == 1);
			for (int run = 0; run < PHASE_RUNS; run++) begin
				pick = $urandom_range(99);
				if (pick < 45)
					send_message($urandom_range(1, 6));
				else if (pick < 80)
					send_codeword($urandom_range(1, 4), 1'b0);
				else if (pick < 90)
					send_codeword($urandom_range(1, 4), 1'b1);
				else
					send_noise($urandom_range(1, 4));
			end
			phase++;
		end
		steady = 1'b0;
	endtask

	// Receiver: random ready, long hold-offs on request, none in steady phases
	initial begin
		int hold_left;
		int hold_done;
		hold_left    = 0;
		hold_done    = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_done) begin
				hold_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res_if.ready <= 1'b0;
				hold_left--;
			end else if (steady) begin
				res_if.ready <= 1'b1;
			end else begin
				res_if.ready <= ($urandom_range(99) >= 15);
			end
		end
	end

	// Compare each output beat with the oldest one due
	always @(posedge clk) begin
		crc_beat_t want;
		crc_beat_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = '{out_bit: res_if.out_bit, out_last: res_if.out_last,
				is_verdict: res_if.is_verdict, check_ok: res_if.check_ok};
			if (crc_out_due.size() == 0) begin
				note_error($sformatf("unexpected beat bit=%b last=%b verdict=%b ok=%b",
					got.out_bit, got.out_last, got.is_verdict, got.check_ok));
			end else begin
				want = crc_out_due.pop_front();
				if (got !== want)
					note_error($sformatf(
						"mismatch: expected bit=%b last=%b verdict=%b ok=%b, got bit=%b last=%b verdict=%b ok=%b",
						want.out_bit, want.out_last, want.is_verdict, want.check_ok,
						got.out_bit, got.out_last, got.is_verdict, got.check_ok));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		cycle_count     = 0;
		err_count       = 0;
		bits_sent       = 0;
		steady          = 1'b0;
		hold_asks       = 0;
		arst_n          = 1'b0;
		msg_if.valid    = 1'b0;
		msg_if.action   = crcbs_pkg::ACTION_ENCODE;
		msg_if.data_bit = 1'b0;
		msg_if.is_final = 1'b0;
		cfg_if.valid    = 1'b0;
		cfg_if.index    = crcbs_pkg::REG_POLY;
		cfg_if.data     = '0;
		cfg_poly        = crcbs_pkg::POLY_RESET;
		cfg_deg         = crcbs_pkg::DEG_RESET;
		crc_rem         = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_config();
		test_degree_extremes();
		test_mode_mix();
		test_config_midrun();
		test_output_stall();
		test_random_traffic();

		quiesce(DRAIN);
		if (crc_out_due.size() != 0)
			note_error($sformatf("%0d beats never arrived", crc_out_due.size()));
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
